// File: src/stbs_pkg.sv
// sorted table bound search: shared constants, codes and the control/status structs
// no dependencies; imported by the controller, the datapath and the top module
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 10;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 4;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_L_LT = 4'd0;
    localparam logic [KIND_W-1:0] KIND_L_LE = 4'd1;
    localparam logic [KIND_W-1:0] KIND_L_EQ = 4'd2;
    localparam logic [KIND_W-1:0] KIND_L_GE = 4'd3;
    localparam logic [KIND_W-1:0] KIND_L_GT = 4'd4;
    localparam logic [KIND_W-1:0] KIND_R_LT = 4'd5;
    localparam logic [KIND_W-1:0] KIND_R_LE = 4'd6;
    localparam logic [KIND_W-1:0] KIND_R_EQ = 4'd7;
    localparam logic [KIND_W-1:0] KIND_R_GE = 4'd8;
    localparam logic [KIND_W-1:0] KIND_R_GT = 4'd9;

    typedef enum logic [2:0] {
        RA_MID,
        RA_LB,
        RA_LBM1,
        RA_UB,
        RA_UBM1
    } raddr_sel_t;

    typedef enum logic [3:0] {
        RES_NONE,
        RES_LB,
        RES_UB,
        RES_LBM1,
        RES_UBM1,
        RES_EQ_LB,
        RES_EQ_UBM1,
        RES_LO,
        RES_LOM1
    } res_sel_t;

    typedef struct packed {
        logic       accept;
        logic       bnd_start;
        logic       bnd_src_rd;
        logic       bnd_strict;
        logic       bnd_step;
        logic       save_lb;
        logic       save_ub;
        raddr_sel_t raddr_sel;
        logic       res_set;
        res_sel_t   res_sel;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic              bnd_done;
        logic              lb_zero;
        logic              ub_zero;
        logic              lb_end;
        logic              ub_end;
        logic [KIND_W-1:0] kind;
        logic              out_busy;
    } status_t;

endpackage

// File: src/stbs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/stbs_ctrl.sv
// sorted table bound search controller: sequences bound searches and result hand-off
// depends on stbs_pkg
module stbs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic [stbs_pkg::OP_W-1:0]   s_operation,
    output logic                        s_ready,
    output stbs_pkg::cmd_t              cmd,
    input  stbs_pkg::status_t           stat
);
    import stbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_CMP,
        S_DECIDE,
        S_FETCH,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_LB,
        PH_UB,
        PH_FIN
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_LB;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.raddr_sel = RA_MID;
        cmd.res_sel   = RES_NONE;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_operation == OP_QUERY) begin
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                cmd.bnd_start = 1'b1;
                phase_next    = PH_LB;
                state_next    = S_PROBE;
            end
            S_PROBE: begin
                if (!stat.bnd_done) begin
                    cmd.raddr_sel = RA_MID;
                    state_next    = S_CMP;
                end else begin
                    case (phase_reg)
                        PH_LB: begin
                            cmd.save_lb    = 1'b1;
                            cmd.bnd_start  = 1'b1;
                            cmd.bnd_strict = 1'b1;
                            phase_next     = PH_UB;
                        end
                        PH_UB: begin
                            cmd.save_ub = 1'b1;
                            state_next  = S_DECIDE;
                        end
                        PH_FIN: begin
                            cmd.res_set = 1'b1;
                            cmd.res_sel = (stat.kind == KIND_R_GE || stat.kind == KIND_R_GT)
                                          ? RES_LOM1 : RES_LO;
                            state_next  = S_OUT;
                        end
                        default: begin
                            cmd.res_set = 1'b1;
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end
            S_CMP: begin
                cmd.bnd_step = 1'b1;
                state_next   = S_PROBE;
            end
            S_DECIDE: begin
                state_next  = S_OUT;
                cmd.res_set = 1'b1;
                case (stat.kind)
                    KIND_L_LT: begin
                        if (!stat.lb_zero) begin
                            cmd.res_set   = 1'b0;
                            cmd.raddr_sel = RA_LBM1;
                            state_next    = S_FETCH;
                        end
                    end
                    KIND_L_LE, KIND_R_EQ: begin
                        if (!stat.ub_zero) begin
                            cmd.res_set   = 1'b0;
                            cmd.raddr_sel = RA_UBM1;
                            state_next    = S_FETCH;
                        end
                    end
                    KIND_L_EQ, KIND_R_GE: begin
                        if (!stat.lb_end) begin
                            cmd.res_set   = 1'b0;
                            cmd.raddr_sel = RA_LB;
                            state_next    = S_FETCH;
                        end
                    end
                    KIND_R_GT: begin
                        if (!stat.ub_end) begin
                            cmd.res_set   = 1'b0;
                            cmd.raddr_sel = RA_UB;
                            state_next    = S_FETCH;
                        end
                    end
                    KIND_L_GE: begin
                        if (!stat.lb_end) begin
                            cmd.res_sel = RES_LB;
                        end
                    end
                    KIND_L_GT: begin
                        if (!stat.ub_end) begin
                            cmd.res_sel = RES_UB;
                        end
                    end
                    KIND_R_LT: begin
                        if (!stat.lb_zero) begin
                            cmd.res_sel = RES_LBM1;
                        end
                    end
                    KIND_R_LE: begin
                        if (!stat.ub_zero) begin
                            cmd.res_sel = RES_UBM1;
                        end
                    end
                    default: begin
                        cmd.res_sel = RES_NONE;
                    end
                endcase
            end
            S_FETCH: begin
                case (stat.kind)
                    KIND_L_EQ: begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_EQ_LB;
                        state_next  = S_OUT;
                    end
                    KIND_R_EQ: begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_EQ_UBM1;
                        state_next  = S_OUT;
                    end
                    KIND_L_LT, KIND_L_LE: begin
                        cmd.bnd_start  = 1'b1;
                        cmd.bnd_src_rd = 1'b1;
                        phase_next     = PH_FIN;
                        state_next     = S_PROBE;
                    end
                    KIND_R_GE, KIND_R_GT: begin
                        cmd.bnd_start  = 1'b1;
                        cmd.bnd_src_rd = 1'b1;
                        cmd.bnd_strict = 1'b1;
                        phase_next     = PH_FIN;
                        state_next     = S_PROBE;
                    end
                    default: begin
                        cmd.res_set = 1'b1;
                        state_next  = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !stat.out_busy)
        else $error("result register overwritten while occupied");

    a_no_accept_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !cmd.accept)
        else $error("word accepted during a search");

    a_query_starts_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_operation == OP_QUERY) |=> (state_reg == S_START))
        else $error("query did not start a search");

endmodule

// File: src/stbs_dp.sv
// sorted table bound search datapath: table store, element count, bound search
// registers and the result register; depends on stbs_pkg and stbs_ram
module stbs_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [stbs_pkg::OP_W-1:0]           s_operation,
    input  logic [stbs_pkg::KIND_W-1:0]         s_query_kind,
    input  logic signed [stbs_pkg::VALUE_WIDTH-1:0] s_value,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic                                m_found,
    output logic [stbs_pkg::POS_W-1:0]          m_position,
    output logic                                m_overflow,
    input  stbs_pkg::cmd_t                      cmd,
    output stbs_pkg::status_t                   stat
);
    import stbs_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    logic [CNT_W-1:0]              count_reg;
    logic                          ovf_reg;
    logic [CNT_W-1:0]              lo_reg, hi_reg;
    logic [CNT_W-1:0]              lb_reg, ub_reg;
    logic signed [VALUE_WIDTH-1:0] target_reg, bnd_tgt_reg;
    logic [KIND_W-1:0]             kind_reg;
    logic                          strict_reg;
    logic                          res_found_reg, res_found_next;
    logic [POS_W-1:0]              res_pos_reg, res_pos_next;
    logic                          m_valid_reg, m_found_reg, m_ovf_reg;
    logic [POS_W-1:0]              m_pos_reg;

    logic [CNT_W-1:0]              mid, rd_cnt;
    logic signed [VALUE_WIDTH-1:0] rd_data;
    logic                          go_right, wr_en, rd_eq;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = strict_reg ? (rd_data <= bnd_tgt_reg) : (rd_data < bnd_tgt_reg);
    assign rd_eq    = (rd_data == target_reg);
    assign wr_en    = cmd.accept && (s_operation == OP_APPEND) && (count_reg < DEPTH_CNT);

    always_comb begin
        case (cmd.raddr_sel)
            RA_LB:   rd_cnt = lb_reg;
            RA_LBM1: rd_cnt = lb_reg - ONE_CNT;
            RA_UB:   rd_cnt = ub_reg;
            RA_UBM1: rd_cnt = ub_reg - ONE_CNT;
            default: rd_cnt = mid;
        endcase
    end

    stbs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_value),
        .raddr (rd_cnt[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        res_found_next = 1'b1;
        res_pos_next   = '0;
        case (cmd.res_sel)
            RES_LB:      res_pos_next = POS_W'(lb_reg);
            RES_UB:      res_pos_next = POS_W'(ub_reg);
            RES_LBM1:    res_pos_next = POS_W'(lb_reg - ONE_CNT);
            RES_UBM1:    res_pos_next = POS_W'(ub_reg - ONE_CNT);
            RES_LO:      res_pos_next = POS_W'(lo_reg);
            RES_LOM1:    res_pos_next = POS_W'(lo_reg - ONE_CNT);
            RES_EQ_LB: begin
                res_found_next = rd_eq;
                res_pos_next   = rd_eq ? POS_W'(lb_reg) : '0;
            end
            RES_EQ_UBM1: begin
                res_found_next = rd_eq;
                res_pos_next   = rd_eq ? POS_W'(ub_reg - ONE_CNT) : '0;
            end
            default:     res_found_next = 1'b0;
        endcase
    end

    // table bookkeeping and bound search registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end else begin
            if (cmd.accept && s_operation == OP_CLEAR) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.accept && s_operation == OP_APPEND) begin
                if (count_reg < DEPTH_CNT) begin
                    count_reg <= count_reg + ONE_CNT;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.bnd_start) begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end else if (cmd.bnd_step) begin
                if (go_right) begin
                    lo_reg <= mid + ONE_CNT;
                end else begin
                    hi_reg <= mid;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            target_reg <= s_value;
            kind_reg   <= s_query_kind;
        end
        if (cmd.bnd_start) begin
            bnd_tgt_reg <= cmd.bnd_src_rd ? rd_data : target_reg;
            strict_reg  <= cmd.bnd_strict;
        end
        if (cmd.save_lb) begin
            lb_reg <= lo_reg;
        end
        if (cmd.save_ub) begin
            ub_reg <= lo_reg;
        end
        if (cmd.res_set) begin
            res_found_reg <= res_found_next;
            res_pos_reg   <= res_pos_next;
        end
        if (cmd.load_out) begin
            m_found_reg <= res_found_reg;
            m_pos_reg   <= res_pos_reg;
            m_ovf_reg   <= ovf_reg;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_pos_reg;
    assign m_overflow = m_ovf_reg;

    assign stat.bnd_done = (lo_reg >= hi_reg);
    assign stat.lb_zero  = (lb_reg == '0);
    assign stat.ub_zero  = (ub_reg == '0);
    assign stat.lb_end   = (lb_reg >= count_reg);
    assign stat.ub_end   = (ub_reg >= count_reg);
    assign stat.kind     = kind_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

    a_bound_order: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= hi_reg)
        else $error("bound search interval inverted");

    a_full_append_sets_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_operation == OP_APPEND && count_reg == DEPTH_CNT) |=> ovf_reg)
        else $error("dropped append did not set overflow");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_operation == OP_CLEAR) |=> (count_reg == '0 && !ovf_reg))
        else $error("clear did not empty the table");

    a_load_shows_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("loaded result word not presented");

endmodule

// File: src/sorted_table_bound_search_unit.sv
// Sorted table bound search. Clear and append words are accepted back to back. A
// query runs a lower and an upper bound search over the n stored entries; each
// search makes up to ceil(log2(n+1)) probes, each a ram read then a compare, and
// the leftmost lt/le and the rightmost ge/gt kinds can run a third search. The
// table ram has a single read port. The result sits in an output register, so a
// following word is accepted while it waits; a further query result waits until
// that register is free.
// depends on stbs_pkg, stbs_ctrl, stbs_dp
module sorted_table_bound_search_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [stbs_pkg::OP_W-1:0]               s_operation,
    input  logic [stbs_pkg::KIND_W-1:0]             s_query_kind,
    input  logic signed [stbs_pkg::VALUE_WIDTH-1:0] s_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_found,
    output logic [stbs_pkg::POS_W-1:0]              m_position,
    output logic                                    m_overflow
);
    import stbs_pkg::*;

    cmd_t    cmd;
    status_t stat;

    stbs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    stbs_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_operation  (s_operation),
        .s_query_kind (s_query_kind),
        .s_value      (s_value),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_found      (m_found),
        .m_position   (m_position),
        .m_overflow   (m_overflow),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// File: sim/tb_sorted_table_bound_search_unit.sv
// testbench for sorted_table_bound_search_unit: directed words, a full-table fill with
// overflow, then random mostly sorted tables and searches checked against an in-bench model
// depends on stbs_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb_sorted_table_bound_search_unit;
    import stbs_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [KIND_W-1:0] KIND_SPARE0 = 4'd10;
    localparam logic [KIND_W-1:0] KIND_MAX    = 4'd15;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX  = 32'sh7fff_ffff;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_NEG1 = 32'shffff_ffff;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_ZERO = 32'sd0;
    localparam longint VAL_MAX_L = 64'sd2147483647;

    localparam int WORD_TARGET    = 1600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 150;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } answer_t;

    typedef struct packed {
        logic [OP_W-1:0]                op;
        logic [KIND_W-1:0]              kind;
        logic signed [VALUE_WIDTH-1:0]  value;
        logic                           typed;
        answer_t                        ans;
    } row_t;

    typedef enum {FILL_DUPS, FILL_NARROW, FILL_WIDE, FILL_SPREAD, FILL_UNSORTED} fill_style_t;

    localparam answer_t NO_ANS = '0;

    // empty table, extremes with duplicates, every search kind, unused codes
    localparam row_t DIRECTED [0:24] = '{
        '{OP_QUERY,  KIND_L_GE,   VAL_ZERO, 1'b1, '{1'b0, 10'd0, 1'b0}},
        '{OP_QUERY,  KIND_R_LE,   VAL_MAX,  1'b1, '{1'b0, 10'd0, 1'b0}},
        '{OP_UNUSED, KIND_MAX,    VAL_NEG1, 1'b0, NO_ANS},
        '{OP_APPEND, KIND_L_LT,   VAL_MIN,  1'b0, NO_ANS},
        '{OP_APPEND, KIND_MAX,    VAL_MIN,  1'b0, NO_ANS},
        '{OP_APPEND, KIND_L_LT,   VAL_NEG1, 1'b0, NO_ANS},
        '{OP_APPEND, KIND_MAX,    VAL_ZERO, 1'b0, NO_ANS},
        '{OP_APPEND, KIND_L_LT,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_APPEND, KIND_MAX,    VAL_ZERO, 1'b0, NO_ANS},
        '{OP_APPEND, KIND_L_LT,   VAL_MAX,  1'b0, NO_ANS},
        '{OP_QUERY,  KIND_L_LT,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_L_LE,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_L_EQ,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_L_GE,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_L_GT,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_R_LT,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_R_LE,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_R_EQ,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_R_GE,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_R_GT,   VAL_ZERO, 1'b0, NO_ANS},
        '{OP_QUERY,  KIND_L_LT,   VAL_MIN,  1'b1, '{1'b0, 10'd0, 1'b0}},
        '{OP_QUERY,  KIND_R_GT,   VAL_MAX,  1'b1, '{1'b0, 10'd0, 1'b0}},
        '{OP_QUERY,  KIND_MAX,    VAL_ZERO, 1'b1, '{1'b0, 10'd0, 1'b0}},
        '{OP_QUERY,  KIND_L_GE,   VAL_MAX,  1'b1, '{1'b1, 10'd6, 1'b0}},
        '{OP_CLEAR,  KIND_SPARE0, VAL_NEG1, 1'b0, NO_ANS}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [OP_W-1:0]               s_operation;
    logic [KIND_W-1:0]             s_query_kind;
    logic signed [VALUE_WIDTH-1:0] s_value;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_found;
    logic [POS_W-1:0]              m_position;
    logic                          m_overflow;

    logic signed [VALUE_WIDTH-1:0] table_vals [TABLE_DEPTH];
    int                            table_len;
    bit                            table_overflow;
    answer_t                       pending_answers [$];
    longint                        run_value;
    int                            words_sent;
    int                            errors;
    int                            idle_cycles;
    bit                            send_burst;
    bit                            recv_burst;

    sorted_table_bound_search_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_query_kind (s_query_kind),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_position   (m_position),
        .m_overflow   (m_overflow)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // first index whose entry exceeds the target (strict) or is at least the target
    function automatic int first_index(logic signed [VALUE_WIDTH-1:0] target, bit strict);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = table_len;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (table_vals[mid] <= target) : (table_vals[mid] < target))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic answer_t search_table(logic [KIND_W-1:0] kind,
                                             logic signed [VALUE_WIDTH-1:0] target);
        answer_t a;
        int      lb;
        int      ub;
        int      pos;
        bit      hit;
        lb  = first_index(target, 1'b0);
        ub  = first_index(target, 1'b1);
        hit = 1'b0;
        pos = 0;
        case (kind)
            KIND_L_LT: if (lb > 0) begin
                hit = 1'b1;
                pos = first_index(table_vals[lb-1], 1'b0);
            end
            KIND_L_LE: if (ub > 0) begin
                hit = 1'b1;
                pos = first_index(table_vals[ub-1], 1'b0);
            end
            KIND_L_EQ: if (lb < table_len) begin
                if (table_vals[lb] == target) begin
                    hit = 1'b1;
                    pos = lb;
                end
            end
            KIND_L_GE: if (lb < table_len) begin
                hit = 1'b1;
                pos = lb;
            end
            KIND_L_GT: if (ub < table_len) begin
                hit = 1'b1;
                pos = ub;
            end
            KIND_R_LT: if (lb > 0) begin
                hit = 1'b1;
                pos = lb - 1;
            end
            KIND_R_LE: if (ub > 0) begin
                hit = 1'b1;
                pos = ub - 1;
            end
            KIND_R_EQ: if (ub > 0) begin
                if (table_vals[ub-1] == target) begin
                    hit = 1'b1;
                    pos = ub - 1;
                end
            end
            KIND_R_GE: if (lb < table_len) begin
                hit = 1'b1;
                pos = first_index(table_vals[lb], 1'b1) - 1;
            end
            KIND_R_GT: if (ub < table_len) begin
                hit = 1'b1;
                pos = first_index(table_vals[ub], 1'b1) - 1;
            end
            default: ;
        endcase
        a.found    = hit;
        a.position = hit ? pos[POS_W-1:0] : '0;
        a.overflow = table_overflow;
        return a;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] next_value(fill_style_t style);
        longint incr;
        case (style)
            FILL_UNSORTED: return $urandom();
            FILL_DUPS:     incr = $urandom_range(0, 1);
            FILL_NARROW:   incr = $urandom_range(0, 50);
            FILL_SPREAD:   incr = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1 << 23);
            default:       incr = $urandom_range(0, 1 << 28);
        endcase
        run_value = run_value + incr;
        if (run_value > VAL_MAX_L)
            run_value = VAL_MAX_L;
        return run_value[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] pick_target();
        logic signed [VALUE_WIDTH-1:0] base;
        base = (table_len > 0) ? table_vals[$urandom_range(0, table_len - 1)] : $urandom();
        case ($urandom_range(0, 7))
            0, 1, 2: return base;
            3:       return base + 1;
            4:       return base - 1;
            5:       return VAL_MIN;
            6:       return VAL_MAX;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        if ($urandom_range(0, 7) == 0)
            return KIND_W'($urandom_range(KIND_SPARE0, KIND_MAX));
        return KIND_W'($urandom_range(KIND_L_LT, KIND_R_GT));
    endfunction

    task automatic put_word(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                            input logic signed [VALUE_WIDTH-1:0] val,
                            input bit typed, input answer_t typed_ans);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_query_kind <= kind;
        s_value      <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (op)
            OP_CLEAR: begin
                table_len      = 0;
                table_overflow = 1'b0;
                words_sent++;
            end
            OP_APPEND: begin
                if (table_len >= TABLE_DEPTH) begin
                    table_overflow = 1'b1;
                end else begin
                    table_vals[table_len] = val;
                    table_len++;
                end
                words_sent++;
            end
            OP_QUERY: begin
                pending_answers.push_back(typed ? typed_ans : search_table(kind, val));
                words_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic append_value(input logic signed [VALUE_WIDTH-1:0] val);
        put_word(OP_APPEND, KIND_W'($urandom_range(0, 15)), val, 1'b0, NO_ANS);
    endtask

    task automatic random_query();
        put_word(OP_QUERY, pick_kind(), pick_target(), 1'b0, NO_ANS);
    endtask

    task automatic clear_table();
        put_word(OP_CLEAR, KIND_W'($urandom_range(0, 15)), $urandom(), 1'b0, NO_ANS);
    endtask

    task automatic noise_word();
        put_word(OP_UNUSED, KIND_W'($urandom_range(0, 15)), $urandom(), 1'b0, NO_ANS);
    endtask

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int      stall;
        answer_t want;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 29) == 0)
                recv_burst = !recv_burst;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: found %0b position %0d overflow %0b",
                         $time, m_found, m_position, m_overflow);
            end else begin
                want = pending_answers.pop_front();
                compare_field("found", want.found, m_found);
                compare_field("position", want.position, m_position);
                compare_field("overflow", want.overflow, m_overflow);
            end
        end
    end

    initial begin
        fill_style_t style;
        int          len;
        int          r;
        errors         = 0;
        words_sent     = 0;
        idle_cycles    = 0;
        table_len      = 0;
        table_overflow = 1'b0;
        send_burst     = 1'b0;
        recv_burst     = 1'b0;
        foreach (table_vals[i]) table_vals[i] = '0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_operation  <= OP_CLEAR;
        s_query_kind <= KIND_L_LT;
        s_value      <= VAL_ZERO;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 25; i++)
            put_word(DIRECTED[i].op, DIRECTED[i].kind, DIRECTED[i].value,
                     DIRECTED[i].typed, DIRECTED[i].ans);

        // whole table, then appends past the end to raise the sticky flag
        clear_table();
        run_value = VAL_MIN;
        for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
            if (i % 32 == 31)
                random_query();
            append_value(next_value(FILL_SPREAD));
        end
        for (int i = 0; i < 40; i++)
            random_query();
        noise_word();
        append_value(VAL_MAX);
        random_query();
        clear_table();
        random_query();

        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 5) != 0)
                clear_table();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
            r   = $urandom_range(0, 11);
            style = (r == 0) ? FILL_UNSORTED : (r < 5) ? FILL_DUPS :
                    (r < 9) ? FILL_NARROW : FILL_WIDE;
            if (table_len > 0)
                run_value = table_vals[table_len-1];
            else if ($urandom_range(0, 3) == 0)
                run_value = VAL_MIN;
            else
                run_value = $signed($urandom());
            for (int i = 0; i < len; i++) begin
                append_value(next_value(style));
                if ($urandom_range(0, 7) == 0)
                    random_query();
                if ($urandom_range(0, 29) == 0)
                    noise_word();
            end
            r = $urandom_range(3, 20);
            for (int i = 0; i < r; i++)
                random_query();
        end
        s_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_ctrl.sv
src/stbs_dp.sv
src/sorted_table_bound_search_unit.sv
sim/tb_sorted_table_bound_search_unit.sv
